[src/wnpm_pkg.sv]
// Shared types and constants for the weighted nearest palette match block.
package wnpm_pkg;

   localparam int COUNT_W = 9;   // palette_count register width
   localparam int COMP_W  = 8;   // one color component
   localparam int WTD_W   = 14;  // |diff| * weight, max 255*59
   localparam int SQ_W    = 28;  // square of a weighted diff
   localparam int DIST_W  = 29;  // sum of three squares

   localparam logic [WTD_W-1:0] WEIGHT_R = WTD_W'(30);
   localparam logic [WTD_W-1:0] WEIGHT_G = WTD_W'(59);
   localparam logic [WTD_W-1:0] WEIGHT_B = WTD_W'(11);

   localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(292742550);

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(256);

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [7:0]        entry_index;
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
      logic              frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0]        match_index;
      logic [DIST_W-1:0] best_distance;
      logic              frame_done;
   } rsp_type;

endpackage

[src/weighted_nearest_palette_match.sv]
// Top level: palette store and pipelined weighted nearest-color search.
//
// Usage:
//  - req_ channel carries two transaction kinds. A palette write stores
//    red/green/blue at entry_index (indices at or above PALETTE_DEPTH are
//    dropped) and gives no result. A pixel transaction scans entries
//    0 to palette_count-1 and gives one rsp_ transaction.
//  - csr_wr_en/csr_wr_data set palette_count (0 acts as 1, values above
//    PALETTE_DEPTH act as PALETTE_DEPTH). Write it only while idle.
//  - A palette write does not raise req_stall; the next may follow at once.
//  - A pixel's search is set by the single read port of the palette
//    memory, one entry per cycle, followed by the distance pipeline, the
//    last compare and the output load. req_stall stays high for the
//    whole search.
//  - The result sits in an output register; a new transaction is accepted
//    while it waits. If a second search finishes before rsp_stall drops,
//    that search holds its result until the slot frees.
//  - Reset sets palette_count to 256 and empties the output slot. Palette
//    contents are undefined until written; no clearing pass is run.
module weighted_nearest_palette_match #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  wnpm_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output wnpm_pkg::rsp_type             rsp_data,
   input  logic                          csr_wr_en,
   input  logic [wnpm_pkg::COUNT_W-1:0]  csr_wr_data
);
   import wnpm_pkg::*;

   localparam int IDX_W = $clog2(PALETTE_DEPTH);
   localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(PALETTE_DEPTH);
   localparam int ENTRY_W = 3 * COMP_W;

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;  // take writes and pixels
   localparam logic [1:0] ST_SCAN  = 2'd1;  // issue one memory read per cycle
   localparam logic [1:0] ST_DRAIN = 2'd2;  // wait for last entry to compare
   localparam logic [1:0] ST_OUT   = 2'd3;  // hand result to output slot

   logic [1:0]   state_ff, state_in;
   logic [COUNT_W-1:0] count_ff;

   // palette memory, one synchronous read port
   logic [ENTRY_W-1:0] palette_mem [PALETTE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [COMP_W-1:0] pix_red_ff, pix_green_ff, pix_blue_ff;
   logic              pix_fe_ff;

   // pipeline tags: s1 = memory data, s2 = weighted diffs, s3 = squares, s4 = sum
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_last_ff, s2_last_ff, s3_last_ff, s4_last_ff;
   logic [IDX_W-1:0] s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;

   logic [WTD_W-1:0]  s2_wr_ff, s2_wg_ff, s2_wb_ff;
   logic [SQ_W-1:0]   s3_sr_ff, s3_sg_ff, s3_sb_ff;
   logic [DIST_W-1:0] s4_dist_ff;

   logic [DIST_W-1:0] best_dist_ff;
   logic [IDX_W-1:0]  best_idx_ff;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   logic [COUNT_W-1:0] count_eff, count_m1;
   logic [IDX_W-1:0]   last_idx;
   logic req_take, take_pixel, take_write, issue, slot_free, load_rsp;
   logic [COMP_W-1:0] dr, dg, db;

   function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                  input logic [COMP_W-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

   // effective search length
   always_comb begin
      if (count_ff == '0) begin
         count_eff = COUNT_W'(1);
      end else if (count_ff > DEPTH_COUNT) begin
         count_eff = DEPTH_COUNT;
      end else begin
         count_eff = count_ff;
      end
      count_m1 = count_eff - COUNT_W'(1);
      last_idx = count_m1[IDX_W-1:0];
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign take_pixel = req_take && (req_data.kind == KIND_PIXEL);
   assign take_write = req_take && (req_data.kind == KIND_WRITE)
                       && ({1'b0, req_data.entry_index} < DEPTH_COUNT);
   assign issue      = (state_ff == ST_SCAN);
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign load_rsp   = (state_ff == ST_OUT) && slot_free;

   // sequencer
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take_pixel) begin
               state_in = ST_SCAN;
               addr_in  = '0;
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + IDX_W'(1);
            if (addr_ff == last_idx) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (s4_valid_ff && s4_last_ff) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= COUNT_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
      addr_ff <= addr_in;
      if (take_pixel) begin
         pix_red_ff   <= req_data.red;
         pix_green_ff <= req_data.green;
         pix_blue_ff  <= req_data.blue;
         pix_fe_ff    <= req_data.frame_end;
      end
   end

   // memory: writes only while idle; the read port samples addr_ff every
   // cycle, but only reads issued while scanning are tagged valid
   always_ff @(posedge clock) begin
      if (take_write) begin
         palette_mem[req_data.entry_index[IDX_W-1:0]] <=
            {req_data.red, req_data.green, req_data.blue};
      end
      rd_data_ff <= palette_mem[addr_ff];
   end

   assign dr = abs_diff(pix_red_ff,   rd_data_ff[3*COMP_W-1:2*COMP_W]);
   assign dg = abs_diff(pix_green_ff, rd_data_ff[2*COMP_W-1:COMP_W]);
   assign db = abs_diff(pix_blue_ff,  rd_data_ff[COMP_W-1:0]);

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      s1_idx_ff  <= addr_ff;
      s1_last_ff <= (addr_ff == last_idx);
      s2_idx_ff  <= s1_idx_ff;
      s2_last_ff <= s1_last_ff;
      s3_idx_ff  <= s2_idx_ff;
      s3_last_ff <= s2_last_ff;
      s4_idx_ff  <= s3_idx_ff;
      s4_last_ff <= s3_last_ff;

      s2_wr_ff <= WTD_W'(dr) * WEIGHT_R;
      s2_wg_ff <= WTD_W'(dg) * WEIGHT_G;
      s2_wb_ff <= WTD_W'(db) * WEIGHT_B;

      s3_sr_ff <= SQ_W'(s2_wr_ff) * SQ_W'(s2_wr_ff);
      s3_sg_ff <= SQ_W'(s2_wg_ff) * SQ_W'(s2_wg_ff);
      s3_sb_ff <= SQ_W'(s2_wb_ff) * SQ_W'(s2_wb_ff);

      s4_dist_ff <= DIST_W'(s3_sr_ff) + DIST_W'(s3_sg_ff) + DIST_W'(s3_sb_ff);

      // running minimum; strict less keeps the lowest index on ties
      if (s4_valid_ff && ((s4_idx_ff == '0) || (s4_dist_ff < best_dist_ff))) begin
         best_dist_ff <= s4_dist_ff;
         best_idx_ff  <= s4_idx_ff;
      end
   end

   // output slot
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_rsp) begin
         rsp_data_ff.match_index   <= 8'(best_idx_ff);
         rsp_data_ff.best_distance <= best_dist_ff;
         rsp_data_ff.frame_done    <= pix_fe_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[src/wnpm_checker.sv]
// Port-level checker for the palette match block, with its bind.
module wnpm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input wnpm_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input wnpm_pkg::rsp_type rsp_data
);
   import wnpm_pkg::*;

   // output slot empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   // a palette write never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.kind == KIND_WRITE && !rsp_valid)
      |=> !rsp_valid)
      else $error("result after palette write");

   // a pixel starts a search that blocks the request side
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.kind == KIND_PIXEL)
      |=> (req_stall && !$rose(rsp_valid)))
      else $error("search did not hold off requests");

   // distance stays in range
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.best_distance <= DIST_MAX))
      else $error("distance out of range");

endmodule

bind weighted_nearest_palette_match wnpm_checker u_wnpm_checker (.*);
